### sv/b2u_pkg.sv
package b2u_pkg;

    localparam int COUNT_BITS = 16;

    typedef logic [COUNT_BITS-1:0] t_count;

    localparam t_count COUNT_MAX = '1;

    localparam logic [2:0] MODE_UTF8    = 3'd0;
    localparam logic [2:0] MODE_WIN1252 = 3'd3;
    localparam logic [2:0] MODE_ROMAN   = 3'd4;

    localparam logic [1:0] REG_ENCODING = 2'd0;
    localparam logic [1:0] REG_CAPACITY = 2'd1;

    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
    localparam logic [15:0] REPL_CHAR      = 16'hFFFD;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COLLECT,
        PH_SKIP
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE,
        EV_CHAR,
        EV_DONE
    } t_ev;

    typedef struct packed {
        logic [15:0] code;
        logic        is_char;
        logic        fits;
        logic [15:0] total;
        logic        last;
    } t_result;

    typedef struct packed {
        t_ev         kind;
        logic [15:0] code;
        t_phase      phase;
        logic [1:0]  trails;
        logic [15:0] partial;
    } t_lead;

    typedef struct packed {
        t_result r;
        t_count  c;
    } t_res_cnt;

    localparam logic [15:0] WIN1252_HI [32] = '{
        16'h20AC, 16'hFFFD, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'hFFFD, 16'h017D, 16'hFFFD,
        16'hFFFD, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'hFFFD, 16'h017E, 16'h0178
    };

    localparam logic [15:0] ROMAN_HI [128] = '{
        16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
        16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
        16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
        16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
        16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
        16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
        16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
        16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
        16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
        16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
        16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
        16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
        16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
        16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
        16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
        16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
    };

    function automatic logic [15:0] total16(input t_count c);
        logic [31:0] w;
        w = 32'(c);
        return (w > 32'h0000FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [15:0] map_byte(input logic [2:0] mode, input logic [7:0] b);
        logic [15:0] r;
        r = {8'h00, b};
        if (mode == MODE_WIN1252 && b[7:5] == 3'b100) begin
            r = WIN1252_HI[b[4:0]];
        end else if (mode == MODE_ROMAN && b[7]) begin
            r = ROMAN_HI[b[6:0]];
        end
        return r;
    endfunction

    // utf-8 byte seen with no sequence in progress
    function automatic t_lead utf8_lead(input logic [7:0] b, input logic [1:0] trails,
                                        input logic [15:0] partial);
        t_lead l;
        l.kind    = EV_NONE;
        l.code    = '0;
        l.phase   = PH_IDLE;
        l.trails  = trails;
        l.partial = partial;
        if (b == 8'h00) begin
            l.kind    = EV_DONE;
            l.trails  = '0;
            l.partial = '0;
        end else if (!b[7]) begin
            l.kind = EV_CHAR;
            l.code = {8'h00, b};
        end else if (b[7:5] == 3'b110) begin
            l.phase   = PH_COLLECT;
            l.trails  = 2'd1;
            l.partial = {11'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            l.phase   = PH_COLLECT;
            l.trails  = 2'd2;
            l.partial = {12'd0, b[3:0]};
        end else begin
            l.kind    = EV_CHAR;
            l.code    = REPL_CHAR;
            l.phase   = PH_SKIP;
            l.trails  = '0;
            l.partial = '0;
        end
        return l;
    endfunction

    // one event against the running character count
    function automatic t_res_cnt count_event(input t_ev kind, input logic [15:0] code,
                                             input t_count c, input logic [15:0] cap);
        t_res_cnt o;
        logic     sat;
        sat = (c == COUNT_MAX);
        o.r.last = 1'b0;
        if (kind == EV_DONE) begin
            o.r.code    = '0;
            o.r.is_char = 1'b0;
            o.r.fits    = 1'b0;
            o.r.total   = total16(c);
            o.c         = '0;
        end else begin
            o.r.code    = code;
            o.r.is_char = 1'b1;
            o.r.fits    = !sat && (32'(c) < 32'(cap));
            o.c         = sat ? c : c + t_count'(1);
            o.r.total   = total16(o.c);
        end
        return o;
    endfunction

endpackage

### sv/byte_text_to_ucs2_transcoder.sv
// byte text to ucs-2 transcoder
// input channel (i_valid/o_ready) takes one text byte per transaction; byte 0
// ends the string. output channel (o_valid/i_ready) gives result transactions:
// a character (o_is_char 1) or the end-of-string done report (o_is_char 0,
// o_char_total holds the total). o_last marks the final result of a byte.
// a byte yields zero, one or two results; two when a utf-8 sequence is cut
// short and the cutting byte itself produces a character or the done report.
// the byte is held in the input register, decoded in a single pass (lead/trail
// decode, code table lookup, count compare) and its results enter a two-entry
// output queue, whose head drives the outputs.
// throughput: one byte per cycle while the receiver takes every result and each
// byte gives at most one result; a byte with two results leaves them in the
// output queue, which hands them out one after the other.
// when the receiver stalls the queue fills, decode holds the byte in the input
// register and o_ready drops; nothing is lost.
// configuration: i_cfg_we writes encoding mode (index 0) or destination
// capacity (index 1); write only while the block is idle.
// reset (synchronous, active low) empties both stages, returns the utf-8
// decoder to idle, clears the character count, selects utf-8 and sets the
// capacity to 65535.
module byte_text_to_ucs2_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_char_code,
    output logic        o_is_char,
    output logic        o_fits,
    output logic [15:0] o_char_total,
    output logic        o_last
);
    import b2u_pkg::*;

    logic [2:0]  r_mode;
    logic [15:0] r_capacity;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_trails, n_trails;
    logic [15:0] r_partial, n_partial;
    t_count      r_count, n_count;

    t_result     r_q [2];
    t_result     n_q [2];
    logic [1:0]  r_q_cnt, n_q_cnt;

    t_ev         ev0_k, ev1_k;
    logic [15:0] ev0_c, ev1_c;
    t_result     res [2];
    logic [1:0]  nres;
    logic        done_seen;
    logic        pop;
    logic        fire;
    logic [2:0]  room;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_UTF8;
            r_capacity <= CAPACITY_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_ENCODING) begin
                r_mode <= i_cfg_data[2:0];
            end else if (i_cfg_idx == REG_CAPACITY) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    // decode of the registered byte
    always_comb begin
        t_lead      ld;
        logic [7:0] b;
        logic       trail;
        logic [1:0] t;
        logic [15:0] p;
        b         = r_in_byte;
        trail     = (b[7:6] == 2'b10);
        n_phase   = r_phase;
        n_trails  = r_trails;
        n_partial = r_partial;
        ev0_k     = EV_NONE;
        ev0_c     = '0;
        ev1_k     = EV_NONE;
        ev1_c     = '0;
        t         = r_trails - 2'd1;
        p         = {r_partial[9:0], b[5:0]};
        ld        = utf8_lead(b, r_trails, r_partial);
        if (r_mode != MODE_UTF8) begin
            n_phase   = PH_IDLE;
            n_trails  = '0;
            n_partial = '0;
            if (b == 8'h00) begin
                ev0_k = EV_DONE;
            end else begin
                ev0_k = EV_CHAR;
                ev0_c = map_byte(r_mode, b);
            end
        end else if (r_phase == PH_COLLECT) begin
            if (trail) begin
                n_trails = t;
                if (t == 2'd0) begin
                    n_phase   = PH_SKIP;
                    n_partial = '0;
                    ev0_k     = EV_CHAR;
                    ev0_c     = p;
                end else begin
                    n_partial = p;
                end
            end else begin
                ld        = utf8_lead(b, 2'd0, 16'd0);
                ev0_k     = EV_CHAR;
                ev0_c     = REPL_CHAR;
                ev1_k     = ld.kind;
                ev1_c     = ld.code;
                n_phase   = ld.phase;
                n_trails  = ld.trails;
                n_partial = ld.partial;
            end
        end else if (!(r_phase == PH_SKIP && trail)) begin
            ev0_k     = ld.kind;
            ev0_c     = ld.code;
            n_phase   = ld.phase;
            n_trails  = ld.trails;
            n_partial = ld.partial;
        end
    end

    // count, capacity and totals
    always_comb begin
        t_res_cnt a0;
        t_res_cnt a1;
        a0        = count_event(ev0_k, ev0_c, r_count, r_capacity);
        a1        = count_event(ev1_k, ev1_c, a0.c, r_capacity);
        nres      = 2'(ev0_k != EV_NONE) + 2'(ev1_k != EV_NONE);
        done_seen = (ev0_k == EV_DONE) || (ev1_k == EV_DONE);
        res[0]      = a0.r;
        res[1]      = a1.r;
        res[0].last = (nres == 2'd1);
        res[1].last = 1'b1;
        n_count     = r_count;
        if (ev1_k != EV_NONE) begin
            n_count = a1.c;
        end else if (ev0_k != EV_NONE) begin
            n_count = a0.c;
        end
    end

    // handshake and output queue
    assign o_valid = (r_q_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign room    = 3'd2 - 3'(r_q_cnt) + 3'(pop);
    assign fire    = r_in_valid && (3'(nres) <= room);
    assign o_ready = !r_in_valid || fire;

    always_comb begin
        t_result    rem [2];
        logic [1:0] remcnt;
        logic [1:0] push;
        logic [1:0] idx;
        if (pop) begin
            rem[0] = r_q[1];
            rem[1] = r_q[1];
            remcnt = r_q_cnt - 2'd1;
        end else begin
            rem[0] = r_q[0];
            rem[1] = r_q[1];
            remcnt = r_q_cnt;
        end
        push = fire ? nres : 2'd0;
        idx  = '0;
        for (int k = 0; k < 2; k++) begin
            idx = 2'(k) - remcnt;
            if (2'(k) < remcnt) begin
                n_q[k] = rem[k];
            end else if (idx < push) begin
                n_q[k] = res[idx[0]];
            end else begin
                n_q[k] = r_q[k];
            end
        end
        n_q_cnt = remcnt + push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_trails   <= '0;
            r_partial  <= '0;
            r_count    <= '0;
            r_q_cnt    <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (fire) begin
                r_phase   <= n_phase;
                r_trails  <= n_trails;
                r_partial <= n_partial;
                r_count   <= n_count;
            end
            r_q_cnt <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_in_byte;
        end
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

    assign o_char_code  = r_q[0].code;
    assign o_is_char    = r_q[0].is_char;
    assign o_fits       = r_q[0].fits;
    assign o_char_total = r_q[0].total;
    assign o_last       = r_q[0].last;

    a_queue_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= 2'd2)
        else $error("output queue overfilled");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && done_seen |=> r_count == '0)
        else $error("count not cleared after terminator");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_char |-> o_last && !o_fits && o_char_code == 16'd0)
        else $error("malformed done result");

    a_collect_trails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_COLLECT |-> r_trails != 2'd0)
        else $error("collecting with no trail bytes pending");

endmodule

### bench/byte_text_to_ucs2_transcoder_tb.sv
`timescale 1ns / 1ps

module byte_text_to_ucs2_transcoder_tb;
    import b2u_pkg::*;

    typedef enum logic [2:0] {
        ENC_UTF8,
        ENC_LATIN1,
        ENC_FONT,
        ENC_WIN1252,
        ENC_ROMAN,
        ENC_SPARE_5,
        ENC_SPARE_6,
        ENC_SPARE_7
    } t_encoding;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam longint unsigned COUNT_CEIL = (64'd1 << COUNT_BITS) - 64'd1;

    localparam logic [15:0] CP1252_UPPER [32] = '{
        16'h20AC, 16'hFFFD, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'hFFFD, 16'h017D, 16'hFFFD,
        16'hFFFD, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'hFFFD, 16'h017E, 16'h0178
    };

    localparam logic [15:0] ROMAN_UPPER [128] = '{
        16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
        16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
        16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
        16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
        16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
        16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
        16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
        16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
        16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
        16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
        16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
        16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
        16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
        16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
        16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
        16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
    };

    // ascii, 2- and 3-byte, overlong, stray trail, 4-byte lead with skipped
    // trails, invalid lead, cut short by a letter and by the terminator
    localparam logic [7:0] UTF8_PROBE [22] = '{
        8'h41, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hEF, 8'hBF, 8'hBF, 8'hC0,
        8'h80, 8'h80, 8'hF0, 8'h9F, 8'h98, 8'hFF, 8'hC3, 8'h41, 8'hE2, 8'h82, 8'h00
    };

    class ucs2_scoreboard;
        logic [2:0]      mode;
        logic [15:0]     capacity;
        t_phase          phase;
        logic [1:0]      trails;
        logic [15:0]     partial;
        longint unsigned chars;
        t_result         expected_q[$];
        int              errors;

        function new();
            mode     = ENC_UTF8;
            capacity = CAPACITY_RESET;
            phase    = PH_IDLE;
            trails   = '0;
            partial  = '0;
            chars    = 0;
            errors   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == REG_ENCODING) begin
                mode = val[2:0];
            end else if (idx == REG_CAPACITY) begin
                capacity = val;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [15:0] clip_total();
            return (chars > 64'hFFFF) ? 16'hFFFF : 16'(chars);
        endfunction

        function void push_char(logic [15:0] code);
            t_result r;
            logic    sat;
            sat       = (chars >= COUNT_CEIL);
            r.code    = code;
            r.is_char = 1'b1;
            r.fits    = !sat && (chars < longint'(capacity));
            if (!sat) begin
                chars++;
            end
            r.total = clip_total();
            r.last  = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void push_done();
            t_result r;
            r.code    = '0;
            r.is_char = 1'b0;
            r.fits    = 1'b0;
            r.total   = clip_total();
            r.last    = 1'b0;
            expected_q.push_back(r);
            chars   = 0;
            phase   = PH_IDLE;
            trails  = '0;
            partial = '0;
        endfunction

        function void fresh_lead(logic [7:0] b);
            if (b == 8'h00) begin
                push_done();
            end else if (!b[7]) begin
                phase = PH_IDLE;
                push_char({8'h00, b});
            end else if (b[7:5] == 3'b110) begin
                phase   = PH_COLLECT;
                trails  = 2'd1;
                partial = {11'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                phase   = PH_COLLECT;
                trails  = 2'd2;
                partial = {12'd0, b[3:0]};
            end else begin
                phase   = PH_SKIP;
                trails  = '0;
                partial = '0;
                push_char(REPL_CHAR);
            end
        endfunction

        function logic [15:0] byte_code(logic [7:0] b);
            if (mode == ENC_WIN1252 && b >= 8'h80 && b <= 8'h9F) begin
                return CP1252_UPPER[b - 8'h80];
            end else if (mode == ENC_ROMAN && b >= 8'h80) begin
                return ROMAN_UPPER[b - 8'h80];
            end
            return {8'h00, b};
        endfunction

        function void note_byte(logic [7:0] b);
            int      before_n;
            logic    trail;
            t_result r;
            before_n = expected_q.size();
            trail    = (b[7:6] == 2'b10);
            if (mode != ENC_UTF8) begin
                phase   = PH_IDLE;
                trails  = '0;
                partial = '0;
                if (b == 8'h00) begin
                    push_done();
                end else begin
                    push_char(byte_code(b));
                end
            end else if (phase == PH_COLLECT) begin
                if (trail) begin
                    partial = (partial << 6) | {10'd0, b[5:0]};
                    trails  = trails - 2'd1;
                    if (trails == 2'd0) begin
                        phase = PH_SKIP;
                        push_char(partial);
                        partial = '0;
                    end
                end else begin
                    phase   = PH_IDLE;
                    trails  = '0;
                    partial = '0;
                    push_char(REPL_CHAR);
                    fresh_lead(b);
                end
            end else if (!(phase == PH_SKIP && trail)) begin
                fresh_lead(b);
            end
            if (expected_q.size() > before_n) begin
                r      = expected_q.pop_back();
                r.last = 1'b1;
                expected_q.push_back(r);
            end
        endfunction

        function void compare(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [15:0] code, logic is_char, logic fits,
                                   logic [15:0] total, logic last);
            t_result e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none actual code %h total %h",
                         $time, code, total);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare("char_code", e.code, code);
            compare("is_char", 16'(e.is_char), 16'(is_char));
            compare("fits", 16'(e.fits), 16'(fits));
            compare("char_total", e.total, total);
            compare("last", 16'(e.last), 16'(last));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = REG_ENCODING;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid    = 1'b0;
    logic [7:0]  i_in_byte  = '0;
    logic        i_ready    = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [15:0] o_char_code;
    logic        o_is_char;
    logic        o_fits;
    logic [15:0] o_char_total;
    logic        o_last;

    ucs2_scoreboard sb;
    int             idle_pct = 30;
    int unsigned    cycles   = 0;

    byte_text_to_ucs2_transcoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_char_code  (o_char_code),
        .o_is_char    (o_is_char),
        .o_fits       (o_fits),
        .o_char_total (o_char_total),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // monitor both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.note_byte(i_in_byte);
            end
            if (o_valid && i_ready) begin
                sb.check_result(o_char_code, o_is_char, o_fits, o_char_total, o_last);
            end
        end
    end

    // receiver stalls
    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // wait out every expected transaction plus the pipeline depth
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic configure(input t_encoding enc, input logic [15:0] cap);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_ENCODING;
        i_cfg_data <= 16'(enc);
        @(posedge i_clk);
        i_cfg_idx  <= REG_CAPACITY;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(REG_ENCODING, 16'(enc));
        sb.set_reg(REG_CAPACITY, cap);
    endtask

    task automatic random_text(input int n);
        int         sent;
        int         pick;
        logic [7:0] cut;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(0, 99);
            if (sb.mode != ENC_UTF8) begin
                send_byte((pick < 6) ? 8'h00 : 8'($urandom_range(1, 255)));
                sent += 1;
            end else if (pick < 8) begin
                send_byte(8'h00);
                sent += 1;
            end else if (pick < 40) begin
                send_byte(8'($urandom_range(1, 127)));
                sent += 1;
            end else if (pick < 60) begin
                send_byte({3'b110, 5'($urandom_range(0, 31))});
                send_byte({2'b10, 6'($urandom_range(0, 63))});
                sent += 2;
            end else if (pick < 78) begin
                send_byte({4'b1110, 4'($urandom_range(0, 15))});
                send_byte({2'b10, 6'($urandom_range(0, 63))});
                send_byte({2'b10, 6'($urandom_range(0, 63))});
                sent += 3;
            end else if (pick < 86) begin
                // sequence broken by a non-continuation byte
                if ($urandom_range(0, 1)) begin
                    send_byte({3'b110, 5'($urandom_range(0, 31))});
                end else begin
                    send_byte({4'b1110, 4'($urandom_range(0, 15))});
                    if ($urandom_range(0, 1)) begin
                        send_byte({2'b10, 6'($urandom_range(0, 63))});
                        sent += 1;
                    end
                end
                do cut = 8'($urandom_range(0, 255)); while (cut[7:6] == 2'b10);
                send_byte(cut);
                sent += 2;
            end else if (pick < 93) begin
                send_byte({2'b10, 6'($urandom_range(0, 63))});
                sent += 1;
            end else begin
                send_byte(8'($urandom_range(0, 255)));
                sent += 1;
            end
        end
    endtask

    initial begin
        logic [15:0] cap;
        t_encoding   enc;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(ENC_UTF8, 16'd2);
        foreach (UTF8_PROBE[k]) begin
            send_byte(UTF8_PROBE[k]);
        end
        settle();

        // pending sequence dropped by a mode switch
        send_byte(8'hE2);
        settle();
        configure(ENC_LATIN1, 16'd0);
        send_byte(8'h82);
        send_byte(8'hFF);
        send_byte(8'h00);
        settle();
        configure(ENC_WIN1252, 16'hFFFF);
        send_byte(8'h80);
        send_byte(8'h9F);
        send_byte(8'h00);
        settle();
        configure(ENC_SPARE_7, 16'hFFFF);
        send_byte(8'h80);
        send_byte(8'h00);
        settle();

        for (int seg = 0; seg < 8; seg++) begin
            case (seg % 3)
                0: idle_pct = 30;
                1: idle_pct = 0;
                default: idle_pct = 60;
            endcase
            if (seg < 5) begin
                enc = t_encoding'(seg);
            end else if ($urandom_range(0, 1)) begin
                enc = ENC_UTF8;
            end else begin
                enc = t_encoding'($urandom_range(0, 7));
            end
            case ($urandom_range(0, 4))
                0: cap = 16'd0;
                1: cap = 16'd1;
                2: cap = 16'($urandom_range(2, 24));
                3: cap = 16'($urandom_range(0, 65535));
                default: cap = 16'hFFFF;
            endcase
            configure(enc, cap);
            random_text(95);
            send_byte(8'h00);
            settle();
        end

        idle_pct = 0;
        configure(ENC_UTF8, 16'd40);
        random_text(40);
        send_byte(8'h00);
        settle();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
